// ===== design/msmc_pkg.sv =====
// Types and constants shared by the multi-shutter motor controller.
// No dependencies.
package msmc_pkg;

    localparam int GROUP_SLOTS = 15;
    localparam int GROUP_SIZE  = 5;
    localparam int LIST_STRIDE = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd2;

    localparam logic [15:0] RST_TRAVEL = 16'd500;
    localparam logic [7:0]  RST_WINDOW = 8'd50;
    localparam logic [7:0]  RST_PAUSE  = 8'd25;

    localparam logic [7:0] F_UP      = 8'h01;
    localparam logic [7:0] F_DN      = 8'h02;
    localparam logic [7:0] F_PUP     = 8'h04;
    localparam logic [7:0] F_BLK     = 8'h10;
    localparam logic [7:0] F_REV     = 8'h20;
    localparam logic [7:0] F_GUP     = 8'h40;
    localparam logic [7:0] F_GDN     = 8'h80;
    localparam logic [7:0] KEEP_STOP = 8'h3c;
    localparam logic [7:0] KEEP_HIGH = 8'hf0;
    localparam logic [7:0] KEEP_PREV = 8'h0c;
    localparam logic [7:0] KEEP_LOW  = 8'h3f;
    localparam logic [7:0] SET_UP    = 8'h05;
    localparam logic [7:0] SET_DN    = 8'h0a;
    localparam logic [7:0] CLR_BLK   = 8'hef;
    localparam logic [7:0] CLR_REV   = 8'hdf;

    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  win;
        logic [3:0]  cnt;
        logic [7:0]  flg;
    } t_entry;

    localparam t_entry RST_ENTRY = '{pos: RST_TRAVEL, win: 8'd0, cnt: 4'd0, flg: F_PUP};

    typedef struct packed {
        logic [15:0] travel;
        logic [7:0]  window;
        logic [7:0]  pause;
    } t_cfg;

    typedef struct packed {
        logic [31:0] relay_drive;
        logic [15:0] blocked_mask;
        logic        conflict_error;
    } t_result;

endpackage

// ===== design/msmc_in_if.sv =====
// Input item channel of the shutter controller.
// No dependencies.
interface msmc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] buttons;
    logic [3:0]  table_shutter;
    logic [3:0]  table_slot;
    logic [4:0]  table_member;

    modport source (output valid, action, buttons, table_shutter, table_slot, table_member,
                    input ready);
    modport sink   (input valid, action, buttons, table_shutter, table_slot, table_member,
                    output ready);
endinterface

// ===== design/msmc_out_if.sv =====
// Result item channel of the shutter controller.
// No dependencies.
interface msmc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] relay_drive;
    logic [15:0] blocked_mask;
    logic        conflict_error;

    modport source (output valid, relay_drive, blocked_mask, conflict_error, input ready);
    modport sink   (input valid, relay_drive, blocked_mask, conflict_error, output ready);
endinterface

// ===== design/multi_shutter_motor_controller.sv =====
// Top level of the multi-shutter motor controller: configuration registers,
// sequencer and result register. Depends on msmc_pkg, msmc_in_if, msmc_out_if, msmc_seq.
//
// After reset the block clears its group table, one entry a cycle, over all SHUTTERS*15
// entries, and accepts no item meanwhile. An item is then worked on alone, with one
// read-modify-write of the shutter state memory at a time: a tick updates each shutter
// in turn; a button sample scans the shutters and updates each one with an edge and each
// group member it visits; a table load writes at most one table entry. A finished result
// waits in an output register while the next item is accepted.
module multi_shutter_motor_controller #(
    parameter int SHUTTERS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [msmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [msmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    msmc_in_if.sink                           i_item,
    msmc_out_if.source                        o_result
);
    import msmc_pkg::*;

    t_cfg    r_cfg;
    t_result res;
    t_result r_out;
    logic    res_valid;
    logic    res_free;
    logic    r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{travel: RST_TRAVEL, window: RST_WINDOW, pause: RST_PAUSE};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRAVEL: r_cfg.travel <= i_cfg_data;
                CFG_WINDOW: r_cfg.window <= i_cfg_data[7:0];
                CFG_PAUSE:  r_cfg.pause  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    msmc_seq #(.SHUTTERS(SHUTTERS)) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_item.valid),
        .o_ready         (i_item.ready),
        .i_action        (i_item.action),
        .i_buttons       (i_item.buttons),
        .i_table_shutter (i_item.table_shutter),
        .i_table_slot    (i_item.table_slot),
        .i_table_member  (i_item.table_member),
        .o_res_valid     (res_valid),
        .i_res_free      (res_free),
        .o_res           (res)
    );

    assign res_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_free) begin
            r_out <= res;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.relay_drive    = r_out.relay_drive;
    assign o_result.blocked_mask   = r_out.blocked_mask;
    assign o_result.conflict_error = r_out.conflict_error;

endmodule

// ===== design/msmc_seq.sv =====
// Sequencer of the shutter controller: shutter state memory, group table memory
// and the read-modify-write walk for ticks, button samples and table loads.
// Depends on msmc_pkg.
module msmc_seq #(
    parameter int SHUTTERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msmc_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic [15:0]         i_buttons,
    input  logic [3:0]          i_table_shutter,
    input  logic [3:0]          i_table_slot,
    input  logic [4:0]          i_table_member,
    output logic                o_res_valid,
    input  logic                i_res_free,
    output msmc_pkg::t_result   o_res
);
    import msmc_pkg::*;

    localparam int SH_W = (SHUTTERS > 1) ? $clog2(SHUTTERS) : 1;
    localparam int TD   = SHUTTERS * GROUP_SLOTS;
    localparam int TA_W = $clog2(TD);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TICK_RD, S_TICK_WR, S_SCAN, S_OWN,
        S_GRP_RD, S_GRP_CHK, S_GRP_MEM, S_FIN, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [SH_W-1:0]     r_idx, n_idx;
    logic [SH_W-1:0]     r_a, n_a;
    logic [TA_W-1:0]     r_clr, n_clr;
    logic [2:0]          r_k, n_k;
    logic [3:0]          r_slot, n_slot;
    logic [SHUTTERS-1:0] r_rise, n_rise, r_fall, n_fall, r_prev, n_prev;
    logic [SHUTTERS-1:0] r_up, n_up, r_dn, n_dn, r_blk, n_blk;
    logic [7:0]          r_rev, n_rev;
    t_entry              r_own, n_own;

    t_entry              r_st_mem [SHUTTERS];
    t_entry              r_st_rd;
    logic [4:0]          r_tb_mem [TD];
    logic [4:0]          r_tb_rd;

    logic                st_we;
    logic [SH_W-1:0]     st_waddr, st_raddr;
    t_entry              st_wdata;
    logic                tb_we;
    logic [TA_W-1:0]     tb_waddr, tb_raddr;
    logic [4:0]          tb_wdata;

    logic                last;
    logic [SHUTTERS-1:0] level;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_waddr] <= st_wdata;
        end
        r_st_rd <= r_st_mem[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tb_we) begin
            r_tb_mem[tb_waddr] <= tb_wdata;
        end
        r_tb_rd <= r_tb_mem[tb_raddr];
    end

    assign last  = (r_idx == SH_W'(SHUTTERS - 1));
    assign level = ~i_buttons[SHUTTERS-1:0];

    always_comb begin
        t_entry              e;
        logic [7:0]          f;
        logic [7:0]          own;
        logic [7:0]          fa;
        logic                same;
        logic                grp_next;
        logic [SHUTTERS-1:0] up_t, dn_t;

        n_state  = r_state;
        n_idx    = r_idx;
        n_a      = r_a;
        n_clr    = r_clr;
        n_k      = r_k;
        n_slot   = r_slot;
        n_rise   = r_rise;
        n_fall   = r_fall;
        n_prev   = r_prev;
        n_up     = r_up;
        n_dn     = r_dn;
        n_blk    = r_blk;
        n_rev    = r_rev;
        n_own    = r_own;
        st_we    = 1'b0;
        st_waddr = r_idx;
        st_wdata = r_own;
        st_raddr = r_idx;
        tb_we    = 1'b0;
        tb_waddr = r_clr;
        tb_wdata = 5'd0;
        tb_raddr = TA_W'(r_idx) * TA_W'(GROUP_SLOTS) + TA_W'(r_slot);
        e        = r_st_rd;
        f        = r_st_rd.flg;
        own      = r_own.flg;
        fa       = r_st_rd.flg;
        same     = 1'b0;
        grp_next = 1'b0;
        up_t     = r_up;
        dn_t     = r_dn;

        case (r_state)
            S_CLEAR: begin
                tb_we    = 1'b1;
                tb_waddr = r_clr;
                tb_wdata = 5'd0;
                if (r_clr < TA_W'(SHUTTERS)) begin
                    st_we    = 1'b1;
                    st_waddr = SH_W'(r_clr);
                    st_wdata = RST_ENTRY;
                end
                if (r_clr == TA_W'(TD - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    case (i_action)
                        ACT_TICK: begin
                            if (r_rev != 8'd0) begin
                                n_rev = r_rev - 8'd1;
                            end
                            n_state = S_TICK_RD;
                        end
                        ACT_SAMPLE: begin
                            n_rise  = ~r_prev & level;
                            n_fall  = r_prev & ~level;
                            n_prev  = level;
                            n_state = S_SCAN;
                        end
                        ACT_LOAD: begin
                            if (5'(i_table_shutter) < 5'(SHUTTERS) &&
                                5'(i_table_slot) < 5'(GROUP_SLOTS)) begin
                                tb_we    = 1'b1;
                                tb_waddr = TA_W'(i_table_shutter) * TA_W'(GROUP_SLOTS)
                                           + TA_W'(i_table_slot);
                                tb_wdata = i_table_member;
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_TICK_RD: begin
                n_state = S_TICK_WR;
            end
            S_TICK_WR: begin
                if (e.win != 8'd0) begin
                    e.win = e.win - 8'd1;
                end else begin
                    e.cnt = 4'd0;
                end
                if (r_rev == 8'd0 && (f & F_REV) != 8'd0) begin
                    f = f & CLR_REV;
                    if ((f & F_PUP) != 8'd0) begin
                        f = (f & KEEP_HIGH) | SET_DN;
                    end else begin
                        f = (f & KEEP_HIGH) | SET_UP;
                    end
                end
                if ((f & F_GUP) != 8'd0) begin
                    if (e.pos < i_cfg.travel) begin
                        e.pos = e.pos + 16'd1;
                    end else begin
                        f = f & KEEP_STOP;
                    end
                end
                if ((f & F_GDN) != 8'd0) begin
                    if (e.pos != 16'd0) begin
                        e.pos = e.pos - 16'd1;
                    end else begin
                        f = f & KEEP_STOP;
                    end
                end
                if ((f & F_UP) != 8'd0 && (f & F_GUP) == 8'd0) begin
                    f = (f & KEEP_LOW) | F_GUP;
                    up_t[r_idx] = 1'b1;
                end
                if ((f & F_DN) != 8'd0 && (f & F_GDN) == 8'd0) begin
                    f = (f & KEEP_LOW) | F_GDN;
                    dn_t[r_idx] = 1'b1;
                end
                if ((f & (F_UP | F_DN)) == 8'd0) begin
                    up_t[r_idx] = 1'b0;
                    dn_t[r_idx] = 1'b0;
                end
                e.flg    = f;
                st_we    = 1'b1;
                st_waddr = r_idx;
                st_wdata = e;
                if (last) begin
                    n_up    = up_t & ~r_blk;
                    n_dn    = dn_t & ~r_blk;
                    n_state = S_DONE;
                end else begin
                    n_up    = up_t;
                    n_dn    = dn_t;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_TICK_RD;
                end
            end
            S_SCAN: begin
                if (r_rise[r_idx] || r_fall[r_idx]) begin
                    n_state = S_OWN;
                end else if (last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OWN: begin
                n_own   = e;
                n_state = S_FIN;
                if (r_fall[r_idx]) begin
                    if (e.win == 8'd0 && e.cnt == 4'd0) begin
                        if ((f & F_BLK) != 8'd0) begin
                            n_own.flg    = f & CLR_BLK;
                            n_blk[r_idx] = 1'b0;
                        end else begin
                            n_own.flg    = (f & KEEP_PREV) | F_BLK;
                            n_blk[r_idx] = 1'b1;
                        end
                    end else begin
                        case (e.cnt)
                            4'd1: begin
                                if ((f & F_BLK) == 8'd0) begin
                                    if ((f & (F_UP | F_DN)) != 8'd0) begin
                                        n_own.flg = f & KEEP_STOP;
                                    end else if ((f & F_PUP) != 8'd0) begin
                                        n_own.flg = (f & KEEP_HIGH) | SET_DN;
                                    end else begin
                                        n_own.flg = (f & KEEP_HIGH) | SET_UP;
                                    end
                                end
                            end
                            4'd2: begin
                                n_slot  = 4'd0;
                                n_k     = 3'd0;
                                n_state = S_GRP_RD;
                            end
                            4'd3: begin
                                n_slot  = 4'(LIST_STRIDE);
                                n_k     = 3'd0;
                                n_state = S_GRP_RD;
                            end
                            4'd4: begin
                                n_slot  = 4'(2 * LIST_STRIDE);
                                n_k     = 3'd0;
                                n_state = S_GRP_RD;
                            end
                            default: begin
                                n_state = S_FIN;
                            end
                        endcase
                    end
                end
            end
            S_GRP_RD: begin
                n_state = S_GRP_CHK;
            end
            S_GRP_CHK: begin
                if (r_tb_rd == 5'd0) begin
                    n_state = S_FIN;
                end else if (r_tb_rd > 5'(SHUTTERS)) begin
                    grp_next = 1'b1;
                end else begin
                    n_a      = SH_W'(r_tb_rd - 5'd1);
                    st_raddr = SH_W'(r_tb_rd - 5'd1);
                    n_state  = S_GRP_MEM;
                end
            end
            S_GRP_MEM: begin
                same     = (r_a == r_idx);
                grp_next = 1'b1;
                if (same) begin
                    e = r_own;
                end
                fa = e.flg;
                if ((fa & F_BLK) == 8'd0) begin
                    if ((own & (F_UP | F_DN)) == 8'd0) begin
                        fa = fa & KEEP_STOP;
                        if (same) begin
                            own = fa;
                        end
                    end
                    if ((own & F_DN) != 8'd0) begin
                        if ((fa & F_GUP) != 8'd0) begin
                            fa    = ((fa & KEEP_STOP) & CLR_REV) | F_REV;
                            n_rev = i_cfg.pause;
                        end else begin
                            fa = (fa & KEEP_HIGH) | SET_DN;
                        end
                        if (same) begin
                            own = fa;
                        end
                    end
                    if ((own & F_UP) != 8'd0) begin
                        if ((fa & F_GDN) != 8'd0) begin
                            fa    = ((fa & KEEP_STOP) & CLR_REV) | F_REV;
                            n_rev = i_cfg.pause;
                        end else begin
                            fa = (fa & KEEP_HIGH) | SET_UP;
                        end
                    end
                    if (same) begin
                        n_own.flg = fa;
                    end else begin
                        e.flg    = fa;
                        st_we    = 1'b1;
                        st_waddr = r_a;
                        st_wdata = e;
                    end
                end
            end
            S_FIN: begin
                e = r_own;
                if (r_rise[r_idx]) begin
                    if (e.cnt == 4'd0) begin
                        e.win = i_cfg.window;
                    end
                    if (e.cnt != 4'd15) begin
                        e.cnt = e.cnt + 4'd1;
                    end
                end
                st_we    = 1'b1;
                st_waddr = r_idx;
                st_wdata = e;
                if (last) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (grp_next) begin
            if (r_k == 3'(GROUP_SIZE - 1)) begin
                n_state = S_FIN;
            end else begin
                n_k     = r_k + 3'd1;
                n_slot  = r_slot + 4'd1;
                n_state = S_GRP_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_idx   <= '0;
            r_a     <= '0;
            r_k     <= '0;
            r_slot  <= '0;
            r_rise  <= '0;
            r_fall  <= '0;
            r_prev  <= '0;
            r_up    <= '0;
            r_dn    <= '0;
            r_blk   <= '0;
            r_rev   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_idx   <= n_idx;
            r_a     <= n_a;
            r_k     <= n_k;
            r_slot  <= n_slot;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_prev  <= n_prev;
            r_up    <= n_up;
            r_dn    <= n_dn;
            r_blk   <= n_blk;
            r_rev   <= n_rev;
        end
        r_own <= n_own;
    end

    always_comb begin
        o_res = '0;
        for (int i = 0; i < SHUTTERS; i++) begin
            o_res.relay_drive[2*i]   = r_dn[i];
            o_res.relay_drive[2*i+1] = r_up[i];
        end
        o_res.blocked_mask   = 16'(r_blk);
        o_res.conflict_error = |(r_up & r_dn);
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_ready)
        else $error("item accepted during table clear");

    a_member_not_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRP_MEM && st_we) |-> st_waddr != r_idx)
        else $error("group write to the owner entry");

    a_tick_masks_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_TICK_WR && r_state == S_DONE) |-> ((r_up | r_dn) & r_blk) == '0)
        else $error("blocked shutter still driven after tick");

    a_group_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k < 3'(GROUP_SIZE))
        else $error("group slot count out of range");

endmodule

// ===== tb/sv/msmc_tb_pkg.sv =====
// Shared stimulus item type for the shutter controller testbench.
// No dependencies.
package msmc_tb_pkg;
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] buttons;
        logic [3:0]  table_shutter;
        logic [3:0]  table_slot;
        logic [4:0]  table_member;
    } t_cmd;
endpackage

// ===== tb/sv/multi_shutter_motor_controller_tb.sv =====
// Testbench for multi_shutter_motor_controller: directed and random button, tick and
// table items, predicted in place and checked against every result item.
// Depends on msmc_pkg, msmc_tb_pkg, msmc_in_if, msmc_out_if and the RTL.
module multi_shutter_motor_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import msmc_pkg::*;
    import msmc_tb_pkg::*;

    localparam int NSH = 16;
    localparam int WATCHDOG = 20000;

    logic i_clk, i_rst_n, i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    msmc_in_if  item_if();
    msmc_out_if res_if();

    multi_shutter_motor_controller #(.SHUTTERS(NSH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_item(item_if.sink), .o_result(res_if.source)
    );

    // shadow controller state
    logic [15:0] travel;
    logic [7:0]  window_len, pause_len;
    logic [15:0] pos [NSH];
    logic [7:0]  wtmr [NSH];
    logic [3:0]  clicks [NSH];
    logic [7:0]  flg [NSH];
    logic [4:0]  groups [NSH*GROUP_SLOTS];
    logic [7:0]  rev_tmr;
    logic [15:0] prev_lvl, up_w, dn_w, blk_w;

    t_cmd    pending[$];
    t_result expected_results[$];
    int errors, accepted_items, checked_results, idle_cycles;
    bit gen_done, hold_rx, stop_tx;

    function automatic void set_group(int nr, int start);
        logic [4:0] m;
        int a;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            m = groups[nr*GROUP_SLOTS + start + i];
            if (m == 0) break;
            if (m > NSH) continue;
            a = m - 1;
            if (flg[a] & F_BLK) continue;
            if (!(flg[nr] & (F_UP | F_DN))) flg[a] = flg[a] & KEEP_STOP;
            if (flg[nr] & F_DN) begin
                if (flg[a] & F_GUP) begin
                    flg[a] = (flg[a] & KEEP_STOP & CLR_REV) | F_REV;
                    rev_tmr = pause_len;
                end else flg[a] = (flg[a] & KEEP_HIGH) | SET_DN;
            end
            if (flg[nr] & F_UP) begin
                if (flg[a] & F_GDN) begin
                    flg[a] = (flg[a] & KEEP_STOP & CLR_REV) | F_REV;
                    rev_tmr = pause_len;
                end else flg[a] = (flg[a] & KEEP_HIGH) | SET_UP;
            end
        end
    endfunction

    function automatic void release_button(int nr);
        logic [7:0] s;
        s = flg[nr];
        if (wtmr[nr] == 0 && clicks[nr] == 0) begin
            if (s & F_BLK) begin
                flg[nr] = s & CLR_BLK;
                blk_w[nr] = 1'b0;
            end else begin
                flg[nr] = (s & KEEP_PREV) | F_BLK;
                blk_w[nr] = 1'b1;
            end
            return;
        end
        case (clicks[nr])
            4'd1: begin
                if (!(s & F_BLK)) begin
                    if (s & (F_UP | F_DN)) flg[nr] = s & KEEP_STOP;
                    else if (s & F_PUP) flg[nr] = (s & KEEP_HIGH) | SET_DN;
                    else flg[nr] = (s & KEEP_HIGH) | SET_UP;
                end
            end
            4'd2: set_group(nr, 0);
            4'd3: set_group(nr, LIST_STRIDE);
            4'd4: set_group(nr, 2*LIST_STRIDE);
            default: ;
        endcase
    endfunction

    function automatic void tick_all();
        if (rev_tmr > 0) rev_tmr--;
        for (int n = 0; n < NSH; n++) begin
            if (wtmr[n] > 0) wtmr[n]--;
            else clicks[n] = 0;
            if (rev_tmr == 0 && (flg[n] & F_REV)) begin
                flg[n] = flg[n] & CLR_REV;
                if (flg[n] & F_PUP) flg[n] = (flg[n] & KEEP_HIGH) | SET_DN;
                else flg[n] = (flg[n] & KEEP_HIGH) | SET_UP;
            end
            if (flg[n] & F_GUP) begin
                if (pos[n] < travel) pos[n]++;
                else flg[n] = flg[n] & KEEP_STOP;
            end
            if (flg[n] & F_GDN) begin
                if (pos[n] > 0) pos[n]--;
                else flg[n] = flg[n] & KEEP_STOP;
            end
            if ((flg[n] & F_UP) && !(flg[n] & F_GUP)) begin
                flg[n] = (flg[n] & KEEP_LOW) | F_GUP;
                up_w[n] = 1'b1;
            end
            if ((flg[n] & F_DN) && !(flg[n] & F_GDN)) begin
                flg[n] = (flg[n] & KEEP_LOW) | F_GDN;
                dn_w[n] = 1'b1;
            end
            if (!(flg[n] & (F_UP | F_DN))) begin
                up_w[n] = 1'b0;
                dn_w[n] = 1'b0;
            end
        end
        up_w &= ~blk_w;
        dn_w &= ~blk_w;
    endfunction

    function automatic t_result shutter_step(t_cmd c);
        logic [15:0] lvl, rise, fall;
        t_result r;
        case (c.action)
            ACT_TICK: tick_all();
            ACT_SAMPLE: begin
                lvl = ~c.buttons;
                rise = ~prev_lvl & lvl;
                fall = prev_lvl & ~lvl;
                prev_lvl = lvl;
                for (int i = 0; i < NSH; i++) begin
                    if (fall[i]) release_button(i);
                    if (rise[i]) begin
                        if (clicks[i] == 0) wtmr[i] = window_len;
                        if (clicks[i] < 15) clicks[i]++;
                    end
                end
            end
            ACT_LOAD:
                if (c.table_slot < GROUP_SLOTS)
                    groups[c.table_shutter*GROUP_SLOTS + c.table_slot] = c.table_member;
            default: ;
        endcase
        for (int i = 0; i < NSH; i++) begin
            r.relay_drive[2*i]   = dn_w[i];
            r.relay_drive[2*i+1] = up_w[i];
        end
        r.blocked_mask = blk_w;
        r.conflict_error = |(up_w & dn_w);
        return r;
    endfunction

    function automatic void reset_shadow();
        travel = RST_TRAVEL;
        window_len = RST_WINDOW;
        pause_len = RST_PAUSE;
        for (int i = 0; i < NSH; i++) begin
            pos[i] = RST_TRAVEL;
            wtmr[i] = 0;
            clicks[i] = 0;
            flg[i] = F_PUP;
        end
        for (int i = 0; i < NSH*GROUP_SLOTS; i++) groups[i] = 0;
        rev_tmr = 0;
        prev_lvl = 0;
        up_w = 0;
        dn_w = 0;
        blk_w = 0;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // driver: bursts and gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                accepted_items++;
                expected_results.push_back(shutter_step(pending.pop_front()));
            end
            if (item_if.valid && !item_if.ready) begin
            end else if (gap_left > 0 || stop_tx || pending.size() == 0) begin
                item_if.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                item_if.valid <= 1'b1;
                {item_if.action, item_if.buttons, item_if.table_shutter,
                 item_if.table_slot, item_if.table_member} <= pending[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                end else burst_left <= burst_left - 1;
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                t_result got, exp_r;
                got = '{res_if.relay_drive, res_if.blocked_mask, res_if.conflict_error};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    checked_results++;
                    if (got.relay_drive !== exp_r.relay_drive) begin
                        $display("%0t: relay_drive exp %h got %h", $time,
                                 exp_r.relay_drive, got.relay_drive);
                        errors++;
                    end
                    if (got.blocked_mask !== exp_r.blocked_mask) begin
                        $display("%0t: blocked_mask exp %h got %h", $time,
                                 exp_r.blocked_mask, got.blocked_mask);
                        errors++;
                    end
                    if (got.conflict_error !== exp_r.conflict_error) begin
                        $display("%0t: conflict_error exp %b got %b", $time,
                                 exp_r.conflict_error, got.conflict_error);
                        errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 37;
            res_if.ready <= !hold_rx && !(stall_phase < 9 && stall_phase[0]) &&
                            ($urandom_range(0, 5) != 0 || stall_phase > 25);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else if (!gen_done || expected_results.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("multi_shutter_motor_controller_tb: errors");
                $finish;
            end
        end
    end

    function automatic t_cmd mk(logic [1:0] a, logic [15:0] b = 16'hffff,
                                 logic [3:0] sh = 4'd0, logic [3:0] sl = 4'd0,
                                 logic [4:0] m = 5'd0);
        t_cmd c;
        c.action = a;
        c.buttons = b;
        c.table_shutter = sh;
        c.table_slot = sl;
        c.table_member = m;
        return c;
    endfunction

    task automatic drain();
        while (pending.size() != 0 || expected_results.size() != 0 || item_if.valid)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TRAVEL: travel = val;
            CFG_WINDOW: window_len = val[7:0];
            CFG_PAUSE:  pause_len = val[7:0];
            default: ;
        endcase
    endtask

    // clicks on one shutter, with ticks to close the window
    task automatic clicks_on(int sh, int n, int ticks_after);
        for (int k = 0; k < n; k++) begin
            pending.push_back(mk(ACT_SAMPLE, ~(16'h1 << sh)));
            pending.push_back(mk(ACT_SAMPLE, 16'hffff));
        end
        repeat (ticks_after) pending.push_back(mk(ACT_TICK));
    endtask

    task automatic random_phase(int n);
        int sh, kind;
        while (n > 0) begin
            kind = $urandom_range(0, 9);
            sh = $urandom_range(0, NSH-1);
            if (kind < 4) begin
                clicks_on(sh, $urandom_range(1, 5), $urandom_range(0, 8));
                n -= 6;
            end else if (kind < 6) begin
                pending.push_back(mk(ACT_SAMPLE, ~(16'h1 << sh)));
                repeat ($urandom_range(1, 10)) pending.push_back(mk(ACT_TICK));
                pending.push_back(mk(ACT_SAMPLE, 16'hffff));
                n -= 6;
            end else if (kind < 7) begin
                pending.push_back(mk(ACT_LOAD, 16'hffff, 4'(sh), 4'($urandom_range(0, 15)),
                                     5'($urandom_range(0, 31))));
                n--;
            end else if (kind < 8) begin
                pending.push_back(mk(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                     5'($urandom_range(0, 31))));
                n--;
            end else begin
                repeat ($urandom_range(1, 6)) pending.push_back(mk(ACT_TICK));
                n -= 3;
            end
        end
    endtask

    initial begin
        errors = 0;
        accepted_items = 0;
        checked_results = 0;
        idle_cycles = 0;
        gen_done = 0;
        hold_rx = 0;
        stop_tx = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TRAVEL;
        i_cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.action = ACT_TICK;
        item_if.buttons = 16'hffff;
        item_if.table_shutter = 4'd0;
        item_if.table_slot = 4'd0;
        item_if.table_member = 5'd0;
        res_if.ready = 1'b0;
        reset_shadow();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: groups, all click counts, long press, reversal, bad entries
        write_reg(CFG_WINDOW, 16'd4);
        write_reg(CFG_PAUSE, 16'd2);
        write_reg(CFG_TRAVEL, 16'd3);
        pending.push_back(mk(ACT_LOAD, 16'hffff, 4'd0, 4'd0, 5'd2));
        pending.push_back(mk(ACT_LOAD, 16'hffff, 4'd0, 4'd1, 5'd17));
        pending.push_back(mk(ACT_LOAD, 16'hffff, 4'd0, 4'd2, 5'd16));
        pending.push_back(mk(ACT_LOAD, 16'hffff, 4'd0, 4'd5, 5'd3));
        pending.push_back(mk(ACT_LOAD, 16'hffff, 4'd0, 4'd10, 5'd1));
        pending.push_back(mk(ACT_LOAD, 16'hffff, 4'd15, 4'd15, 5'd31));
        pending.push_back(mk(2'd3, 16'h0000));
        clicks_on(1, 1, 2);
        clicks_on(0, 1, 2);
        clicks_on(0, 2, 6);
        clicks_on(0, 3, 6);
        clicks_on(0, 4, 6);
        clicks_on(0, 6, 6);
        pending.push_back(mk(ACT_SAMPLE, 16'h0000));
        repeat (6) pending.push_back(mk(ACT_TICK));
        pending.push_back(mk(ACT_SAMPLE, 16'hffff));
        gen_done = 0;
        drain();

        write_reg(CFG_TRAVEL, 16'hffff);
        write_reg(CFG_WINDOW, 16'd255);
        write_reg(CFG_PAUSE, 16'd0);
        random_phase(300);
        // long receiver hold while items keep coming
        hold_rx = 1;
        repeat (600) @(posedge i_clk);
        hold_rx = 0;
        drain();

        write_reg(CFG_TRAVEL, 16'd1);
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_PAUSE, 16'd255);
        random_phase(350);
        drain();

        write_reg(CFG_TRAVEL, 16'd40);
        write_reg(CFG_WINDOW, 16'd6);
        write_reg(CFG_PAUSE, 16'd3);
        random_phase(700);
        gen_done = 1;
        drain();

        $display("covered %0d items, %0d results checked, four register settings",
                 accepted_items, checked_results);
        if (errors == 0) begin
            $display("multi_shutter_motor_controller_tb: clean");
        end else begin
            $display("multi_shutter_motor_controller_tb: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/msmc_pkg.sv
design/msmc_in_if.sv
design/msmc_out_if.sv
design/msmc_seq.sv
design/multi_shutter_motor_controller.sv
tb/sv/msmc_tb_pkg.sv
tb/sv/multi_shutter_motor_controller_tb.sv
